### sv/owtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared constants for the one-wire temperature reader: counter widths,
// command codes, register indexes and the ROM/function command bytes.
// ----------------------------------------------------------------------------
package owtr_pkg;

  // width of the phase tick counter
  localparam int TICK_COUNT_WIDTH = 16;
  // width of the configuration registers
  localparam int CFG_WIDTH = 16;
  // compare width wide enough for counter + 1 and for any duration
  localparam int CMP_WIDTH =
    ((TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH) + 1;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CONVERT = 2'd1,
    CMD_READOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RESET_LOW = 2'd0,
    REG_SHORT     = 2'd1,
    REG_SLOT      = 2'd2,
    REG_GAP       = 2'd3
  } cfg_reg_t;

  // bus command bytes
  localparam logic [7:0] BYTE_SKIP_ROM = 8'hCC;
  localparam logic [7:0] BYTE_CONVERT  = 8'h44;
  localparam logic [7:0] BYTE_READ_PAD = 8'hBE;

  // reset values of the timing registers
  localparam logic [CFG_WIDTH-1:0] RESET_LOW_DEFAULT = 16'd480;
  localparam logic [CFG_WIDTH-1:0] SHORT_DEFAULT     = 16'd5;
  localparam logic [CFG_WIDTH-1:0] SLOT_DEFAULT      = 16'd60;
  localparam logic [CFG_WIDTH-1:0] GAP_DEFAULT       = 16'd500;

endpackage

### sv/onewire_temperature_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// One-wire bus master for a single temperature sensor. Every input item is
// one timer tick: the sequencer advances one step, drives or releases the
// line and samples it in read slots. Readouts report tenths of a degree.
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------------
//   in       in_valid / in_stall    command, bus_level
//   out      out_valid / out_stall  drive_low, busy_res, result_valid,
//                                   raw_reading, temperature_tenths
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock cycle while in_stall is low; its result is ready in the
// output register in the cycle after acceptance. All work for a tick is one
// pass of sequencer logic between the state and the output registers.
// Reset (synchronous) restores the default timings and an idle sequencer.
// in_stall rises only while a result sits in the output register and
// out_stall holds it; cfg_ready is always high.
// ----------------------------------------------------------------------------
module onewire_temperature_reader
  import owtr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic                  bus_level,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  drive_low,
  output logic                  busy_res,
  output logic                  result_valid,
  output logic [15:0]           raw_reading,
  output logic [15:0]           temperature_tenths,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_RST_REL = 4'd2,
    PH_GAP     = 4'd3,
    PH_WR_LOW  = 4'd4,
    PH_WR_HIGH = 4'd5,
    PH_RD_LOW  = 4'd6,
    PH_RD_REL  = 4'd7,
    PH_RD_REC  = 4'd8
  } phase_t;

  localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX = '1;

  // timing registers
  logic [CFG_WIDTH-1:0] reset_low_ticks;
  logic [CFG_WIDTH-1:0] short_ticks;
  logic [CFG_WIDTH-1:0] slot_ticks;
  logic [CFG_WIDTH-1:0] gap_ticks;

  // sequencer state
  phase_t                      phase, phase_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [1:0]                  byte_index, byte_index_next;
  logic [7:0]                  shift_byte, shift_byte_next;
  logic [7:0]                  low_byte, low_byte_next;
  logic                        readout_mode, readout_mode_next;
  logic [15:0]                 last_raw, last_raw_next;

  // per-tick results
  logic                 drive_next;
  logic                 busy_next;
  logic                 valid_next;
  logic [15:0]          tenths_next;
  logic [19:0]          scaled;
  logic [CFG_WIDTH-1:0] phase_len;
  logic                 done;
  logic                 in_accept;
  logic                 start;
  phase_t               phase_start;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // a command in idle starts with the first reset-low tick
  assign start       = (phase == PH_IDLE) &&
                       (command == CMD_CONVERT || command == CMD_READOUT);
  assign phase_start = start ? PH_RST_LOW : phase;

  // duration of the current phase
  always_comb begin
    unique case (phase_start)
      PH_RST_LOW: phase_len = reset_low_ticks;
      PH_RST_REL: phase_len = short_ticks;
      PH_GAP:     phase_len = gap_ticks;
      PH_WR_LOW:  phase_len = shift_byte[0] ? short_ticks : slot_ticks;
      PH_WR_HIGH: phase_len = shift_byte[0] ? slot_ticks : short_ticks;
      PH_RD_LOW:  phase_len = short_ticks;
      PH_RD_REL:  phase_len = short_ticks;
      default:    phase_len = slot_ticks;
    endcase
  end

  // one sequencer step for the current tick
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    shift_byte_next   = shift_byte;
    low_byte_next     = low_byte;
    readout_mode_next = readout_mode;
    last_raw_next     = last_raw;
    drive_next        = 1'b0;
    busy_next         = 1'b0;
    valid_next        = 1'b0;
    done              = 1'b0;

    // a command in idle starts with the first reset-low tick
    if (start) begin
      phase_next        = PH_RST_LOW;
      tick_count_next   = '0;
      bit_index_next    = '0;
      byte_index_next   = '0;
      shift_byte_next   = BYTE_SKIP_ROM;
      readout_mode_next = (command == CMD_READOUT);
    end

    if (phase_next != PH_IDLE) begin
      busy_next  = 1'b1;
      drive_next = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                   (phase_next == PH_RD_LOW);
      done = ((CMP_WIDTH'(tick_count_next) + CMP_WIDTH'(1)) >= CMP_WIDTH'(phase_len)) ||
             (tick_count_next == CNT_MAX);
      tick_count_next = tick_count_next + 1'b1;
      if (done) begin
        tick_count_next = '0;
        unique case (phase_next)
          PH_RST_LOW: phase_next = PH_RST_REL;
          PH_RST_REL: phase_next = PH_GAP;
          PH_GAP:     phase_next = PH_WR_LOW;
          PH_WR_LOW:  phase_next = PH_WR_HIGH;
          PH_WR_HIGH: begin
            bit_index_next = bit_index_next + 1'b1;
            if (bit_index_next != 3'd0) begin
              shift_byte_next = shift_byte_next >> 1;
              phase_next      = PH_WR_LOW;
            end else begin
              byte_index_next = byte_index_next + 1'b1;
              if (byte_index_next == 2'd1) begin
                shift_byte_next = readout_mode_next ? BYTE_READ_PAD : BYTE_CONVERT;
                phase_next      = PH_WR_LOW;
              end else if (readout_mode_next) begin
                byte_index_next = 2'd2;
                shift_byte_next = '0;
                phase_next      = PH_RD_LOW;
              end else begin
                phase_next = PH_IDLE;
              end
            end
          end
          PH_RD_LOW: phase_next = PH_RD_REL;
          PH_RD_REL: begin
            // sample on the last released tick, bits arrive lsb first
            shift_byte_next = {bus_level, shift_byte_next[7:1]};
            phase_next      = PH_RD_REC;
          end
          default: begin
            bit_index_next = bit_index_next + 1'b1;
            if (bit_index_next != 3'd0) begin
              phase_next = PH_RD_LOW;
            end else if (byte_index_next == 2'd2) begin
              low_byte_next   = shift_byte_next;
              shift_byte_next = '0;
              byte_index_next = 2'd3;
              phase_next      = PH_RD_LOW;
            end else begin
              last_raw_next = {shift_byte_next, low_byte_next};
              valid_next    = 1'b1;
              phase_next    = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  // tenths of a degree: (raw * 10 + 8) >> 4
  assign scaled      = ({4'd0, last_raw_next} << 3) + ({4'd0, last_raw_next} << 1) + 20'd8;
  assign tenths_next = scaled[19:4];

  // state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks <= RESET_LOW_DEFAULT;
      short_ticks     <= SHORT_DEFAULT;
      slot_ticks      <= SLOT_DEFAULT;
      gap_ticks       <= GAP_DEFAULT;
      phase           <= PH_IDLE;
      tick_count      <= '0;
      bit_index       <= '0;
      byte_index      <= '0;
      shift_byte      <= '0;
      low_byte        <= '0;
      readout_mode    <= 1'b0;
      last_raw        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RESET_LOW: reset_low_ticks <= cfg_data;
          REG_SHORT:     short_ticks     <= cfg_data;
          REG_SLOT:      slot_ticks      <= cfg_data;
          REG_GAP:       gap_ticks       <= cfg_data;
          default:       ;
        endcase
      end
      if (in_accept) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_index    <= bit_index_next;
        byte_index   <= byte_index_next;
        shift_byte   <= shift_byte_next;
        low_byte     <= low_byte_next;
        readout_mode <= readout_mode_next;
        last_raw     <= last_raw_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low          <= drive_next;
      busy_res           <= busy_next;
      result_valid       <= valid_next;
      raw_reading        <= last_raw_next;
      temperature_tenths <= tenths_next;
    end
  end

endmodule
